/* src/lad_pkg.sv */
package lad_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int SQ_W      = 32;
  localparam int ROOT_W    = 16;
  localparam int REM_W     = 18;
  localparam int MAG_W     = 17;
  localparam int THR_W     = 15;
  localparam int DIGITS    = 16;
  localparam int CNT_W     = 4;

  localparam logic [THR_W-1:0] THR_RESET = 15'd2560;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT_LOAD,
    ST_ROOT,
    ST_WINDOW,
    ST_FLAG
  } lad_state_e;

  typedef struct packed {
    logic load;
    logic step;
  } lad_ctrl_t;

endpackage

/* src/launch_acceleration_detector_unit.sv */
// channel   direction  handshake                  payload
// in        input      in_valid_i / in_stall_o    imu1_x/y/z_i, imu2_x/y/z_i
// out       output     out_valid_o / out_stall_i  launch_seen_o
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_launch_threshold_i
//
// one item goes from acceptance to result through 16 bit-serial square
// steps, 1 root load, 16 bit-serial root steps, 1 window update, 1 compare;
// a new item is taken only in the idle state, once the last one is through.
// reset clears the window, the running total and sets the threshold to 2560.
// the next item is taken while a result waits in the output register; a
// stalled output holds the following result in the compare step.
module launch_acceleration_detector_unit #(
  parameter int WINDOW_LEN = 5
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [lad_pkg::SAMPLE_W-1:0] imu1_x_i,
  input  logic signed [lad_pkg::SAMPLE_W-1:0] imu1_y_i,
  input  logic signed [lad_pkg::SAMPLE_W-1:0] imu1_z_i,
  input  logic signed [lad_pkg::SAMPLE_W-1:0] imu2_x_i,
  input  logic signed [lad_pkg::SAMPLE_W-1:0] imu2_y_i,
  input  logic signed [lad_pkg::SAMPLE_W-1:0] imu2_z_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               launch_seen_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lad_pkg::THR_W-1:0]          cfg_launch_threshold_i
);
  import lad_pkg::*;

  lad_state_e        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  lad_ctrl_t         sq_ctrl, rt_ctrl;
  logic              win_push;
  logic              out_load;
  logic              out_valid_q, out_valid_d;
  logic              launch_seen_q;
  logic [THR_W-1:0]  threshold_q;
  logic [SQ_W-1:0]   sum1, sum2;
  logic [ROOT_W-1:0] root1, root2;
  logic [MAG_W-1:0]  pair;
  logic              launch;
  logic              last_digit;
  logic              out_free;

  lad_sumsq u_sumsq1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (sq_ctrl),
    .x_i    (imu1_x_i),
    .y_i    (imu1_y_i),
    .z_i    (imu1_z_i),
    .sum_o  (sum1)
  );

  lad_sumsq u_sumsq2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (sq_ctrl),
    .x_i    (imu2_x_i),
    .y_i    (imu2_y_i),
    .z_i    (imu2_z_i),
    .sum_o  (sum2)
  );

  lad_isqrt u_isqrt1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (rt_ctrl),
    .rad_i  (sum1),
    .root_o (root1)
  );

  lad_isqrt u_isqrt2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (rt_ctrl),
    .rad_i  (sum2),
    .root_o (root2)
  );

  assign pair = MAG_W'(root1) + MAG_W'(root2);

  lad_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (win_push),
    .pair_i      (pair),
    .threshold_i (threshold_q),
    .launch_o    (launch)
  );

  assign last_digit = (cnt_q == CNT_W'(DIGITS - 1));
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    sq_ctrl  = '0;
    rt_ctrl  = '0;
    win_push = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          sq_ctrl.load = 1'b1;
          cnt_d        = '0;
          state_d      = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        sq_ctrl.step = 1'b1;
        cnt_d        = cnt_q + CNT_W'(1);
        if (last_digit) begin
          state_d = ST_ROOT_LOAD;
        end
      end
      ST_ROOT_LOAD: begin
        rt_ctrl.load = 1'b1;
        cnt_d        = '0;
        state_d      = ST_ROOT;
      end
      ST_ROOT: begin
        rt_ctrl.step = 1'b1;
        cnt_d        = cnt_q + CNT_W'(1);
        if (last_digit) begin
          state_d = ST_WINDOW;
        end
      end
      ST_WINDOW: begin
        win_push = 1'b1;
        state_d  = ST_FLAG;
      end
      ST_FLAG: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      threshold_q <= THR_RESET;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        threshold_q <= cfg_launch_threshold_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      launch_seen_q <= launch;
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign launch_seen_o = launch_seen_q;
  assign cfg_ready_o   = 1'b1;

endmodule

/* src/lad_sumsq.sv */
module lad_sumsq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lad_pkg::lad_ctrl_t               ctrl_i,
  input  logic signed [lad_pkg::SAMPLE_W-1:0] x_i,
  input  logic signed [lad_pkg::SAMPLE_W-1:0] y_i,
  input  logic signed [lad_pkg::SAMPLE_W-1:0] z_i,
  output logic [lad_pkg::SQ_W-1:0]         sum_o
);
  import lad_pkg::*;

  logic [SAMPLE_W-1:0] ax_q, ay_q, az_q;
  logic [SAMPLE_W-1:0] mx_q, my_q, mz_q;
  logic [SAMPLE_W-1:0] ax_d, ay_d, az_d;
  logic [SAMPLE_W-1:0] mx_d, my_d, mz_d;
  logic [SQ_W-1:0]     acc_q, acc_d;
  logic [SAMPLE_W+1:0] digit_sum;

  function automatic logic [SAMPLE_W-1:0] mag16(input logic [SAMPLE_W-1:0] v);
    if (v[SAMPLE_W-1]) begin
      return ~v + SAMPLE_W'(1);
    end
    return v;
  endfunction

  // msb-first shift-and-add, one multiplier bit per cycle for all three axes
  always_comb begin
    digit_sum = (mx_q[SAMPLE_W-1] ? {2'b00, ax_q} : '0)
              + (my_q[SAMPLE_W-1] ? {2'b00, ay_q} : '0)
              + (mz_q[SAMPLE_W-1] ? {2'b00, az_q} : '0);
    ax_d  = ax_q;
    ay_d  = ay_q;
    az_d  = az_q;
    mx_d  = mx_q;
    my_d  = my_q;
    mz_d  = mz_q;
    acc_d = acc_q;
    if (ctrl_i.load) begin
      ax_d  = mag16(x_i);
      ay_d  = mag16(y_i);
      az_d  = mag16(z_i);
      mx_d  = mag16(x_i);
      my_d  = mag16(y_i);
      mz_d  = mag16(z_i);
      acc_d = '0;
    end else if (ctrl_i.step) begin
      mx_d  = {mx_q[SAMPLE_W-2:0], 1'b0};
      my_d  = {my_q[SAMPLE_W-2:0], 1'b0};
      mz_d  = {mz_q[SAMPLE_W-2:0], 1'b0};
      acc_d = {acc_q[SQ_W-2:0], 1'b0} + SQ_W'(digit_sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q  <= '0;
      ay_q  <= '0;
      az_q  <= '0;
      mx_q  <= '0;
      my_q  <= '0;
      mz_q  <= '0;
      acc_q <= '0;
    end else begin
      ax_q  <= ax_d;
      ay_q  <= ay_d;
      az_q  <= az_d;
      mx_q  <= mx_d;
      my_q  <= my_d;
      mz_q  <= mz_d;
      acc_q <= acc_d;
    end
  end

  assign sum_o = acc_q;

endmodule

/* src/lad_isqrt.sv */
module lad_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lad_pkg::lad_ctrl_t          ctrl_i,
  input  logic [lad_pkg::SQ_W-1:0]    rad_i,
  output logic [lad_pkg::ROOT_W-1:0]  root_o
);
  import lad_pkg::*;

  logic [SQ_W-1:0]   rad_q, rad_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  diff;

  // one root bit per cycle, two radicand bits shifted in
  always_comb begin
    rem_sh = {rem_q, rad_q[SQ_W-1:SQ_W-2]};
    trial  = (REM_W+2)'({root_q, 2'b01});
    diff   = rem_sh - trial;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (ctrl_i.load) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (ctrl_i.step) begin
      rad_d = {rad_q[SQ_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = diff[REM_W-1:0];
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[REM_W-1:0];
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign root_o = root_q;

endmodule

/* src/lad_window.sv */
module lad_window #(
  parameter int WINDOW_LEN = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [lad_pkg::MAG_W-1:0]   pair_i,
  input  logic [lad_pkg::THR_W-1:0]   threshold_i,
  output logic                        launch_o
);
  import lad_pkg::*;

  localparam int TOT_W = MAG_W + $clog2(WINDOW_LEN);
  localparam int BND_W = THR_W + $clog2(2 * WINDOW_LEN);
  localparam int CMP_W = (TOT_W > BND_W) ? TOT_W : BND_W;

  logic [MAG_W-1:0] win_q [WINDOW_LEN];
  logic [MAG_W-1:0] win_d [WINDOW_LEN];
  logic [TOT_W-1:0] total_q, total_d;
  logic [CMP_W-1:0] bound;

  // running total: oldest leaves, newest enters
  always_comb begin
    win_d   = win_q;
    total_d = total_q;
    if (push_i) begin
      for (int i = 0; i < WINDOW_LEN - 1; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[WINDOW_LEN-1] = pair_i;
      total_d = total_q - TOT_W'(win_q[0]) + TOT_W'(pair_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_q[i] <= '0;
      end
      total_q <= '0;
    end else begin
      win_q   <= win_d;
      total_q <= total_d;
    end
  end

  assign bound    = CMP_W'(threshold_i) * CMP_W'(2 * WINDOW_LEN);
  assign launch_o = (CMP_W'(total_q) >= bound);

endmodule
